// ----- rtl/gfau_pkg.sv -----
// ============================================================================
// gfau_pkg
// shared types, constants and the reduction tap table of the GF(2^m) unit
// ============================================================================
`default_nettype none

package gfau_pkg;

    localparam int DATA_W     = 64;
    localparam int DEG_W      = 4;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [DEG_W-1:0] DEG_RESET   = 4'd8;
    localparam logic             REG_DEGREE  = 1'b0;

    typedef logic [DEG_W-1:0] t_bytes;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_MUL = 2'd1,
        OP_INV = 2'd2
    } t_op;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // three middle taps per degree, one row per byte count
    localparam logic [2:0] TAP_TABLE [24] = '{
        3'd4, 3'd3, 3'd1, 3'd5, 3'd3, 3'd1, 3'd4, 3'd3, 3'd1, 3'd7, 3'd3, 3'd2,
        3'd5, 3'd4, 3'd3, 3'd5, 3'd3, 3'd2, 3'd7, 3'd4, 3'd2, 3'd4, 3'd3, 3'd1
    };

    // reduction polynomial without its x^m term
    function automatic logic [7:0] poly_low(input t_bytes bytes);
        logic [4:0] row;
        logic [7:0] p;
        row = 5'(3 * (bytes - 4'd1));
        p   = 8'd1;
        p[TAP_TABLE[row]]        = 1'b1;
        p[TAP_TABLE[row + 5'd1]] = 1'b1;
        p[TAP_TABLE[row + 5'd2]] = 1'b1;
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gf2m_field_arithmetic_unit.sv -----
// ============================================================================
// gf2m_field_arithmetic_unit
// GF(2^m) add, multiply and invert in polynomial basis, m = 8 * degree_bytes
// ============================================================================
//  channel   ports                                        handshake
//  command   i_op, i_operand_a, i_operand_b               start & !busy
//  result    o_result, o_zero_inverse                     o_valid, one cycle
//  config    psel penable pwrite paddr pwdata prdata      apb, pready tied high
//
//  add and unused op: no datapath steps, the result is registered as S_RUN ends
//  multiply: one bit of operand_b per cycle
//  invert: one shift step of the inversion loop per cycle
//  one item at a time; busy is high from accept until the result strobe
//  reset (synchronous, active low) sets degree_bytes to 8 and idles the unit
//  results cannot be stalled; o_valid lasts exactly one cycle
// ============================================================================
`default_nettype none

module gf2m_field_arithmetic_unit #(
    parameter int MAX_DEGREE = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 start,
    output logic                                busy,
    input  wire  [1:0]                          i_op,
    input  wire  [gfau_pkg::DATA_W-1:0]         i_operand_a,
    input  wire  [gfau_pkg::DATA_W-1:0]         i_operand_b,
    output logic                                o_valid,
    output logic [gfau_pkg::DATA_W-1:0]         o_result,
    output logic                                o_zero_inverse,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [gfau_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [gfau_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [gfau_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import gfau_pkg::*;

    localparam t_bytes MAX_BYTES = DEG_W'(MAX_DEGREE / 8);

    t_bytes                r_degree;
    t_bytes                eff_bytes;
    t_dp_cmd               dp_cmd;
    logic [MAX_DEGREE-1:0] dp_result;
    logic                  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[APB_ADDR_W-1:2] == REG_DEGREE);
    assign prdata = (paddr[APB_ADDR_W-1:2] == REG_DEGREE) ? APB_DATA_W'(r_degree) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_degree <= DEG_RESET;
        end else if (cfg_wr) begin
            r_degree <= pwdata[DEG_W-1:0];
        end
    end

    always_comb begin
        if (r_degree == '0) begin
            eff_bytes = DEG_W'(1);
        end else if (r_degree > MAX_BYTES) begin
            eff_bytes = MAX_BYTES;
        end else begin
            eff_bytes = r_degree;
        end
    end

    gfau_ctrl #(
        .W (MAX_DEGREE)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_bytes (eff_bytes),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_cmd   (dp_cmd)
    );

    gfau_dp #(
        .W (MAX_DEGREE)
    ) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (dp_cmd),
        .i_op           (i_op),
        .i_operand_a    (i_operand_a[MAX_DEGREE-1:0]),
        .i_operand_b    (i_operand_b[MAX_DEGREE-1:0]),
        .i_bytes        (eff_bytes),
        .o_result       (dp_result),
        .o_zero_inverse (o_zero_inverse)
    );

    assign o_result = DATA_W'(dp_result);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_zero_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_inverse |-> o_result == '0)
        else $error("inverse of zero gave nonzero result");

endmodule

`default_nettype wire

// ----- rtl/gfau_ctrl.sv -----
// ============================================================================
// gfau_ctrl
// sequencer: accepts an item, counts datapath steps, issues the result strobe
// ============================================================================
`default_nettype none

module gfau_ctrl #(
    parameter int W = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_start,
    input  wire  [1:0]            i_op,
    input  wire gfau_pkg::t_bytes i_bytes,
    output logic                  o_busy,
    output logic                  o_valid,
    output gfau_pkg::t_dp_cmd     o_cmd
);
    import gfau_pkg::*;

    localparam int CW = $clog2(2 * W + 1);

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic            r_valid;
    logic [CW-1:0]   m_val;
    logic [CW-1:0]   n_steps;

    assign m_val = CW'({i_bytes, 3'b000});

    always_comb begin
        case (i_op)
            OP_MUL:  n_steps = m_val - 1'b1;
            OP_INV:  n_steps = m_val << 1;
            default: n_steps = '0;
        endcase
    end

    assign o_busy       = (r_state == S_RUN);
    assign o_valid      = r_valid;
    assign o_cmd.load   = i_start && (r_state == S_IDLE);
    assign o_cmd.step   = (r_state == S_RUN) && (r_cnt != '0);
    assign o_cmd.finish = (r_state == S_RUN) && (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= n_steps;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (r_cnt == '0) begin
                        r_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/gfau_dp.sv -----
// ============================================================================
// gfau_dp
// datapath: xor add, bit-serial multiply, 2m-step binary inversion
// ============================================================================
`default_nettype none

module gfau_dp #(
    parameter int W = 64
) (
    input  wire                   i_clk,
    input  wire gfau_pkg::t_dp_cmd i_cmd,
    input  wire  [1:0]            i_op,
    input  wire  [W-1:0]          i_operand_a,
    input  wire  [W-1:0]          i_operand_b,
    input  wire gfau_pkg::t_bytes i_bytes,
    output logic [W-1:0]          o_result,
    output logic                  o_zero_inverse
);
    import gfau_pkg::*;

    localparam int PW  = W + 1;
    localparam int IW  = $clog2(PW);
    localparam int TW  = $clog2(W);
    localparam int CW  = $clog2(2 * W + 1);

    logic [1:0]     r_op;
    logic [PW-1:0]  r_p;
    logic [PW-1:0]  r_q;
    logic [W-1:0]   r_u;
    logic [W-1:0]   r_v;
    logic [CW-1:0]  r_delta;
    logic           r_zero;
    logic [W-1:0]   r_res;
    logic           r_zflag;

    logic [IW-1:0]  m_val;
    logic [TW-1:0]  top_idx;
    logic [W-1:0]   mask;
    logic [W-1:0]   pl;
    logic [PW-1:0]  p_full;
    logic [W-1:0]   a_m;
    logic [W-1:0]   b_m;
    logic [W-1:0]   mul_p;
    logic [W-1:0]   u_x;
    logic [W-1:0]   u_div;
    logic [PW-1:0]  s_xor;
    logic [W-1:0]   v_xor;
    logic [W-1:0]   v_x;
    logic           p_top;
    logic           s_top;

    function automatic logic [W-1:0] f_xtime(
        input logic [W-1:0]  val,
        input logic [TW-1:0] top,
        input logic [W-1:0]  msk,
        input logic [W-1:0]  pol
    );
        logic [W-1:0] sh;
        sh = (val << 1) & msk;
        return val[top] ? (sh ^ pol) : sh;
    endfunction

    assign m_val   = IW'({i_bytes, 3'b000});
    assign top_idx = TW'(m_val - 1'b1);
    assign pl      = W'(poly_low(i_bytes));
    assign p_full  = {1'b0, pl} | (PW'(1) << m_val);

    always_comb begin
        for (int i = 0; i < W; i++) begin
            mask[i] = (IW'(i) < m_val);
        end
    end

    assign a_m   = i_operand_a & mask;
    assign b_m   = i_operand_b & mask;
    assign mul_p = f_xtime(r_p[W-1:0], top_idx, mask, pl);
    assign u_x   = f_xtime(r_u, top_idx, mask, pl);
    assign u_div = r_u[0] ? (((r_u ^ pl) >> 1) | (W'(1) << top_idx)) : (r_u >> 1);
    assign p_top = r_p[m_val];
    assign s_top = r_q[m_val];
    assign s_xor = s_top ? (r_q ^ r_p) : r_q;
    assign v_xor = s_top ? (r_v ^ r_u) : r_v;
    assign v_x   = f_xtime(v_xor, top_idx, mask, pl);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_zero  <= 1'b0;
            r_delta <= '0;
            r_v     <= '0;
            case (i_op)
                OP_ADD: begin
                    r_u <= a_m ^ b_m;
                end
                OP_MUL: begin
                    r_p <= {1'b0, a_m};
                    r_q <= {1'b0, b_m >> 1};
                    r_u <= b_m[0] ? a_m : '0;
                end
                OP_INV: begin
                    r_p    <= {1'b0, a_m};
                    r_q    <= p_full;
                    r_u    <= W'(1);
                    r_zero <= (a_m == '0);
                end
                default: begin
                    r_u <= '0;
                end
            endcase
        end else if (i_cmd.step) begin
            case (r_op)
                OP_MUL: begin
                    r_p <= {1'b0, mul_p};
                    r_q <= r_q >> 1;
                    if (r_q[0]) begin
                        r_u <= r_u ^ mul_p;
                    end
                end
                OP_INV: begin
                    if (!p_top) begin
                        r_p     <= r_p << 1;
                        r_u     <= u_x;
                        r_delta <= r_delta + 1'b1;
                    end else if (r_delta == '0) begin
                        r_p     <= s_xor << 1;
                        r_q     <= r_p;
                        r_u     <= v_x;
                        r_v     <= r_u;
                        r_delta <= CW'(1);
                    end else begin
                        r_q     <= s_xor << 1;
                        r_v     <= v_xor;
                        r_u     <= u_div;
                        r_delta <= r_delta - 1'b1;
                    end
                end
                default: begin
                    r_u <= r_u;
                end
            endcase
        end else if (i_cmd.finish) begin
            r_res   <= r_zero ? '0 : (r_u & mask);
            r_zflag <= r_zero;
        end
    end

    assign o_result       = r_res;
    assign o_zero_inverse = r_zflag;

endmodule

`default_nettype wire

// ----- tb/gf2m_field_arithmetic_unit_test.sv -----
// ============================================================================
// gf2m_field_arithmetic_unit_test
// self-checking bench for the GF(2^m) unit, directed corners and random phases
// ============================================================================
`timescale 1ns / 1ps

module gf2m_field_arithmetic_unit_test;

    import gfau_pkg::*;

    localparam int          ELEM_W      = DATA_W;
    localparam int          CYCLE_LIMIT = 1_000_000;
    localparam int          DRAIN_WAIT  = 140;
    localparam int          PHASE_ITEMS = 123;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam logic [APB_ADDR_W-1:0] DEGREE_ADDR = APB_ADDR_W'(4 * int'(REG_DEGREE));

    typedef struct {
        logic [ELEM_W-1:0] result;
        logic              zero_inverse;
    } t_field_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic [1:0]              i_op;
    logic [ELEM_W-1:0]       i_operand_a;
    logic [ELEM_W-1:0]       i_operand_b;
    logic                    o_valid;
    logic [ELEM_W-1:0]       o_result;
    logic                    o_zero_inverse;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [APB_ADDR_W-1:0]   paddr;
    logic [APB_DATA_W-1:0]   pwdata;
    logic [APB_DATA_W-1:0]   prdata;
    logic                    pready;

    t_field_result           pending_results [$];
    t_field_result           oldest_result;
    logic [DEG_W-1:0]        degree_setting;
    bit                      idle_bursts;
    int                      mismatches;
    int                      cycle_count;

    gf2m_field_arithmetic_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_op           (i_op),
        .i_operand_a    (i_operand_a),
        .i_operand_b    (i_operand_b),
        .o_valid        (o_valid),
        .o_result       (o_result),
        .o_zero_inverse (o_zero_inverse),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // field arithmetic predictor
    // ------------------------------------------------------------------------
    function automatic int field_bytes(input logic [DEG_W-1:0] setting);
        if (setting == 0) begin
            return 1;
        end
        if (setting > 8) begin
            return 8;
        end
        return int'(setting);
    endfunction

    function automatic logic [ELEM_W-1:0] field_mask(input int m);
        if (m >= ELEM_W) begin
            return '1;
        end
        return (64'd1 << m) - 64'd1;
    endfunction

    // x^t0 + x^t1 + x^t2 + 1 for each byte count
    function automatic logic [ELEM_W-1:0] reduction_low(input int bytes);
        case (bytes)
            1: begin
                return 64'h1B;
            end
            2: begin
                return 64'h2B;
            end
            3: begin
                return 64'h1B;
            end
            4: begin
                return 64'h8D;
            end
            5: begin
                return 64'h39;
            end
            6: begin
                return 64'h2D;
            end
            7: begin
                return 64'h95;
            end
            default: begin
                return 64'h1B;
            end
        endcase
    endfunction

    function automatic int poly_degree_plus1(input logic [ELEM_W-1:0] v);
        for (int i = ELEM_W - 1; i >= 0; i--) begin
            if (v[i]) begin
                return i + 1;
            end
        end
        return 0;
    endfunction

    function automatic logic [ELEM_W-1:0] field_product(
        input logic [ELEM_W-1:0] a,
        input logic [ELEM_W-1:0] b,
        input int                m,
        input logic [ELEM_W-1:0] mask,
        input logic [ELEM_W-1:0] low
    );
        logic [ELEM_W-1:0] acc;
        logic [ELEM_W-1:0] shifted;
        logic              carry;
        shifted = a;
        acc     = b[0] ? a : '0;
        for (int i = 1; i < m; i++) begin
            carry   = shifted[m-1];
            shifted = (shifted << 1) & mask;
            if (carry) begin
                shifted ^= low;
            end
            if (b[i]) begin
                acc ^= shifted;
            end
        end
        return acc & mask;
    endfunction

    function automatic logic [ELEM_W-1:0] field_inverse(
        input logic [ELEM_W-1:0] a,
        input int                m,
        input logic [ELEM_W-1:0] mask,
        input logic [ELEM_W-1:0] low
    );
        logic [ELEM_W-1:0] u, v, z, g, t;
        int                k, lu, lv, iter;
        if (a == 64'd1) begin
            return 64'd1;
        end
        // first step clears the x^m term of the modulus
        k    = m + 1 - poly_degree_plus1(a);
        u    = low ^ ((a << k) & mask);
        v    = a;
        z    = 64'd1 << k;
        g    = 64'd1;
        iter = 0;
        while (iter < 4 * ELEM_W && u != 64'd1 && u != 64'd0) begin
            lu = poly_degree_plus1(u);
            lv = poly_degree_plus1(v);
            if (lu < lv) begin
                t = u; u = v; v = t;
                t = z; z = g; g = t;
                k = lv - lu;
            end else begin
                k = lu - lv;
            end
            if (k < ELEM_W) begin
                u ^= v << k;
                z ^= g << k;
            end
            u &= mask;
            z &= mask;
            iter++;
        end
        return z & mask;
    endfunction

    function automatic t_field_result field_outcome(
        input logic [1:0]        op,
        input logic [ELEM_W-1:0] a_raw,
        input logic [ELEM_W-1:0] b_raw
    );
        t_field_result     r;
        int                bytes, m;
        logic [ELEM_W-1:0] mask, low, a, b;
        bytes          = field_bytes(degree_setting);
        m              = 8 * bytes;
        mask           = field_mask(m);
        low            = reduction_low(bytes);
        a              = a_raw & mask;
        b              = b_raw & mask;
        r.result       = '0;
        r.zero_inverse = 1'b0;
        case (op)
            OP_ADD: begin
                r.result = a ^ b;
            end
            OP_MUL: begin
                r.result = field_product(a, b, m, mask, low);
            end
            OP_INV: begin
                if (a == '0) begin
                    r.zero_inverse = 1'b1;
                end else begin
                    r.result = field_inverse(a, m, mask, low);
                end
            end
            default: begin
                r.result = '0;
            end
        endcase
        r.result &= mask;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // result monitor and run limit
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h %b",
                         $time, o_result, o_zero_inverse);
                mismatches++;
            end else begin
                oldest_result = pending_results.pop_front();
                if (o_result !== oldest_result.result) begin
                    $display("%0t: result: expected %h, actual %h",
                             $time, oldest_result.result, o_result);
                    mismatches++;
                end
                if (o_zero_inverse !== oldest_result.zero_inverse) begin
                    $display("%0t: zero_inverse: expected %b, actual %b",
                             $time, oldest_result.zero_inverse, o_zero_inverse);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // shared driving tasks
    // ------------------------------------------------------------------------
    task automatic send_item(
        input logic [1:0]        op,
        input logic [ELEM_W-1:0] a,
        input logic [ELEM_W-1:0] b
    );
        start       <= 1'b1;
        i_op        <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        do begin
            @(posedge i_clk);
        end while (busy);
        pending_results.push_back(field_outcome(op, a, b));
        start <= 1'b0;
        @(posedge i_clk);
        if (idle_bursts && $urandom_range(0, 3) == 0) begin
            // sometimes hold the gap until the unit frees up
            if ($urandom_range(0, 1) == 0) begin
                while (busy) begin
                    @(posedge i_clk);
                end
            end
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        while (busy) begin
            @(posedge i_clk);
        end
    endtask

    task automatic configure_degree(input logic [DEG_W-1:0] value);
        wait_results_drained();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= DEGREE_ADDR;
        pwdata  <= {$urandom_range(0, 1) ? 28'hFFF_FFFF : 28'h0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        degree_setting = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DATA_W'(value)) begin
            $display("%0t: degree_bytes readback: expected %h, actual %h",
                     $time, APB_DATA_W'(value), prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(0, 9))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            2: begin
                return 64'd1 << $urandom_range(0, ELEM_W - 1);
            end
            3: begin
                return ELEM_W'($urandom_range(0, 255));
            end
            4: begin
                return 64'd1;
            end
            default: begin
                return {$urandom, $urandom};
            end
        endcase
    endfunction

    function automatic logic [1:0] random_op();
        int pick;
        pick = $urandom_range(0, 15);
        if (pick < 5) begin
            return OP_ADD;
        end
        if (pick < 11) begin
            return OP_MUL;
        end
        if (pick < 15) begin
            return OP_INV;
        end
        return OP_UNUSED;
    endfunction

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_reset_degree();
        // reset value is 64-bit field; read it back before any write
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= DEGREE_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== APB_DATA_W'(DEG_RESET)) begin
            $display("%0t: degree_bytes after reset: expected %h, actual %h",
                     $time, APB_DATA_W'(DEG_RESET), prdata);
            mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic test_full_degree_corners();
        send_item(OP_ADD, '1, 64'h5555_5555_5555_5555);
        send_item(OP_MUL, '1, '1);
        send_item(OP_MUL, '0, 64'hDEAD_BEEF_0123_4567);
        send_item(OP_MUL, 64'd1, '1);
        send_item(OP_MUL, 64'h8000_0000_0000_0000, 64'd2);
        send_item(OP_INV, '0, '1);
        send_item(OP_INV, 64'd1, '0);
        send_item(OP_INV, '1, '0);
        send_item(OP_INV, 64'h8000_0000_0000_0000, '1);
        send_item(OP_UNUSED, '1, '1);
    endtask

    task automatic test_narrow_degree_corners();
        configure_degree(4'd1);
        send_item(OP_ADD, '1, 64'h0000_0000_0000_0000);
        send_item(OP_MUL, '1, 64'hFFFF_FFFF_FFFF_FF00 | 64'hFF);
        // only bits at or above m set, so the element is zero
        send_item(OP_INV, 64'h100, '0);
        send_item(OP_INV, 64'h80, '0);
    endtask

    task automatic test_degree_clamping();
        configure_degree(4'd0);
        send_item(OP_MUL, 64'h80, 64'h02);
        send_item(OP_INV, 64'h53, '0);
        configure_degree(4'd15);
        send_item(OP_MUL, '1, 64'h8000_0000_0000_0000);
        send_item(OP_INV, 64'd2, '0);
        configure_degree(4'd9);
        send_item(OP_UNUSED, 64'h1234, 64'h5678);
        send_item(OP_ADD, '1, '0);
    endtask

    task automatic test_random_phases();
        logic [DEG_W-1:0] settings [13];
        settings = '{4'd1, 4'd8, 4'd0, 4'd3, 4'd15, 4'd2, 4'd5, 4'd12, 4'd4, 4'd6,
                     4'd7, 4'd9, 4'd8};
        for (int p = 0; p < 13; p++) begin
            configure_degree(settings[p]);
            // every third phase and the last phase run back to back
            idle_bursts = (p % 3 != 2) && (p != 12);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (n == PHASE_ITEMS / 2 && p == 1) begin
                    wait_results_drained();
                end else if ($urandom_range(0, 63) == 0 && p != 12) begin
                    wait_results_drained();
                end
                send_item(random_op(), random_element(), random_element());
            end
        end
    endtask

    initial begin
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_op           <= OP_ADD;
        i_operand_a    <= '0;
        i_operand_b    <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        degree_setting = DEG_RESET;
        idle_bursts    = 1'b1;
        mismatches     = 0;
        cycle_count    = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_degree();
        test_full_degree_corners();
        test_narrow_degree_corners();
        test_degree_clamping();
        test_random_phases();

        wait_results_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
